>>> sv/sbsm_pkg.sv
`default_nettype none

package sbsm_pkg;

  // field widths
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned TARGET_W = 2;
  localparam int unsigned MAP_W    = 18;
  localparam int unsigned REG_W    = 5;
  localparam int unsigned BANK_W   = 4;

  // bank window offsets: 16 KB prg, 4 KB chr
  localparam int unsigned PRG_OFS_W = 14;
  localparam int unsigned CHR_OFS_W = 12;

  // register reset values and fixed patterns
  localparam logic [REG_W-1:0] LOADER_INIT     = 5'h10;
  localparam logic [REG_W-1:0] CONTROL_INIT    = 5'h0C;
  localparam logic [REG_W-1:0] PRG_FIX_BITS    = 5'h0C;
  localparam logic [REG_W-1:0] BANK_COUNT_INIT = 5'd16;
  localparam logic [REG_W-1:0] BANK_COUNT_MAX  = 5'd16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CPU_RD = 2'd0,
    FUNC_CPU_WR = 2'd1,
    FUNC_PPU_RD = 2'd2,
    FUNC_PPU_WR = 2'd3
  } func_e;

  typedef enum logic [TARGET_W-1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_ROM = 2'd1,
    TGT_PRG_RAM = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  // register picked by address bits 14:13 on a completed serial load
  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_CHR0    = 2'd1,
    REG_CHR1    = 2'd2,
    REG_PRG     = 2'd3
  } reg_sel_e;

  // prg banking mode, control bits 3:2
  typedef enum logic [1:0] {
    PRG_MODE_32K_A   = 2'd0,
    PRG_MODE_32K_B   = 2'd1,
    PRG_MODE_FIX_LOW = 2'd2,
    PRG_MODE_FIX_TOP = 2'd3
  } prg_mode_e;

  // banking state seen by the address mapper
  typedef struct packed {
    logic [REG_W-1:0]  control;
    logic [BANK_W-1:0] prg_sel;
    logic [BANK_W-1:0] chr_lo;
    logic [BANK_W-1:0] chr_hi;
    logic [BANK_W-1:0] last_bank;
  } bank_state_t;

endpackage

`default_nettype wire

>>> sv/sbsm_req_if.sv
`default_nettype none

interface sbsm_req_if;
  import sbsm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_value;

  modport source (output valid, output func, output bus_address, output write_value,
                  input ready);
  modport sink (input valid, input func, input bus_address, input write_value,
                output ready);
endinterface

`default_nettype wire

>>> sv/sbsm_rsp_if.sv
`default_nettype none

interface sbsm_rsp_if;
  import sbsm_pkg::*;

  logic                valid;
  logic                ready;
  logic [TARGET_W-1:0] target;
  logic [MAP_W-1:0]    mapped_address;
  logic                chr_write_enable;
  logic [DATA_W-1:0]   ram_read_data;
  logic                ram_data_valid;

  modport source (output valid, output target, output mapped_address,
                  output chr_write_enable, output ram_read_data, output ram_data_valid,
                  input ready);
  modport sink (input valid, input target, input mapped_address,
                input chr_write_enable, input ram_read_data, input ram_data_valid,
                output ready);
endinterface

`default_nettype wire

>>> sv/sbsm_bank_regs.sv
`default_nettype none

module sbsm_bank_regs (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          wr_en_i,
  input  wire  [1:0]                   wr_sel_i,
  input  wire  [sbsm_pkg::DATA_W-1:0]  wr_data_i,
  input  wire                          cfg_we_i,
  input  wire  [sbsm_pkg::REG_W-1:0]   cfg_wdata_i,
  output sbsm_pkg::bank_state_t        state_o
);
  import sbsm_pkg::*;

  logic [REG_W-1:0]  loader_q, loader_d;
  logic [REG_W-1:0]  control_q, control_d;
  logic [BANK_W-1:0] prg_q, prg_d;
  logic [BANK_W-1:0] chr_lo_q, chr_lo_d;
  logic [BANK_W-1:0] chr_hi_q, chr_hi_d;
  logic [REG_W-1:0]  count_q;
  logic [REG_W-1:0]  shifted;
  logic [REG_W-1:0]  count_m1;
  logic [BANK_W-1:0] last_bank;

  // serial loader: lsb first, marker bit reaching bit 0 means the fifth bit
  assign shifted = {wr_data_i[0], loader_q[REG_W-1:1]};

  always_comb begin
    loader_d  = loader_q;
    control_d = control_q;
    prg_d     = prg_q;
    chr_lo_d  = chr_lo_q;
    chr_hi_d  = chr_hi_q;
    if (wr_en_i) begin
      if (wr_data_i[DATA_W-1]) begin
        loader_d  = LOADER_INIT;
        control_d = control_q | PRG_FIX_BITS;
      end else if (!loader_q[0]) begin
        loader_d = shifted;
      end else begin
        loader_d = LOADER_INIT;
        case (reg_sel_e'(wr_sel_i))
          REG_CONTROL: control_d = shifted;
          REG_CHR0:    chr_lo_d  = shifted[BANK_W-1:0];
          REG_CHR1:    chr_hi_d  = shifted[BANK_W-1:0];
          REG_PRG:     prg_d     = shifted[BANK_W-1:0];
          default:     loader_d  = LOADER_INIT;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loader_q  <= LOADER_INIT;
      control_q <= CONTROL_INIT;
      prg_q     <= '0;
      chr_lo_q  <= '0;
      chr_hi_q  <= '0;
    end else begin
      loader_q  <= loader_d;
      control_q <= control_d;
      prg_q     <= prg_d;
      chr_lo_q  <= chr_lo_d;
      chr_hi_q  <= chr_hi_d;
    end
  end

  // bank count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= BANK_COUNT_INIT;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // last bank, count clamped to 1..16
  assign count_m1 = count_q - 5'd1;

  always_comb begin
    if (count_q == '0) begin
      last_bank = '0;
    end else if (count_q > BANK_COUNT_MAX) begin
      last_bank = '1;
    end else begin
      last_bank = count_m1[BANK_W-1:0];
    end
  end

  assign state_o.control   = control_q;
  assign state_o.prg_sel   = prg_q;
  assign state_o.chr_lo    = chr_lo_q;
  assign state_o.chr_hi    = chr_hi_q;
  assign state_o.last_bank = last_bank;

`ifndef SYNTHESIS
  a_reset_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && wr_data_i[DATA_W-1] |=> loader_q == LOADER_INIT && control_q[3:2] == 2'b11)
    else $error("reset write did not clear the loader or fix prg mode");
  a_fifth_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && !wr_data_i[DATA_W-1] && loader_q[0] |=> loader_q == LOADER_INIT)
    else $error("loader not rearmed after fifth bit");
  a_loader_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en_i |=> $stable(loader_q) && $stable(control_q) && $stable(prg_q))
    else $error("bank state changed without a register write");
`endif

endmodule

`default_nettype wire

>>> sv/serial_bank_switch_mapper.sv
// Serial bank-switch mapper for banked PRG ROM, internal PRG RAM and CHR. One bus access enters
// per cycle on req_i and its single result leaves on rsp_o after passing the decode stage register,
// which captures the decode together with the registered PRG RAM read, and then the output
// register. Throughput is one access per cycle; an output stall backs up through the two stages.
// CPU writes at $8000 and above shift into the serial loader and the bank registers change at the
// edge the write is taken, so the next access already sees the new banking. A RAM write lands in
// the array at the edge it is taken, before any later read can sample it, so no forwarding is
// needed. PRG RAM holds garbage after reset until written. cfg_we_i loads the PRG bank count.
`default_nettype none

module serial_bank_switch_mapper #(
  parameter int unsigned PRG_RAM_BYTES = 8192
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire  [sbsm_pkg::REG_W-1:0]  cfg_wdata_i,
  sbsm_req_if.sink                    req_i,
  sbsm_rsp_if.source                  rsp_o
);
  import sbsm_pkg::*;

  localparam int unsigned RAM_AW = $clog2(PRG_RAM_BYTES);
  localparam logic [15:0] RamBytes = 16'(PRG_RAM_BYTES);

  bank_state_t         bank;
  logic                accept;
  logic                s1_move;
  logic                reg_wr;
  logic                ram_we, ram_re;
  logic [15:0]         ram_off;
  logic [RAM_AW-1:0]   ram_idx;
  logic [TARGET_W-1:0] dec_target;
  logic [MAP_W-1:0]    dec_mapped;
  logic                dec_wen;
  logic [BANK_W-1:0]   rom_bank;
  logic [BANK_W-1:0]   chr_bank;
  logic                is_cpu;

  logic                s1_valid_q, s1_valid_d;
  logic [TARGET_W-1:0] s1_target_q;
  logic [MAP_W-1:0]    s1_mapped_q;
  logic                s1_wen_q;
  logic                s1_rvalid_q;
  logic [DATA_W-1:0]   rd_q;

  logic                out_valid_q, out_valid_d;
  logic [TARGET_W-1:0] out_target_q;
  logic [MAP_W-1:0]    out_mapped_q;
  logic                out_wen_q;
  logic [DATA_W-1:0]   out_rdata_q;
  logic                out_rvalid_q;

  logic [DATA_W-1:0]   mem [PRG_RAM_BYTES];

  // handshake
  assign s1_move     = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_move;
  assign accept      = req_i.valid && req_i.ready;
  assign is_cpu      = (req_i.func == FUNC_CPU_RD) || (req_i.func == FUNC_CPU_WR);

  // bank registers and serial loader
  sbsm_bank_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (reg_wr),
    .wr_sel_i    (req_i.bus_address[14:13]),
    .wr_data_i   (req_i.write_value),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .state_o     (bank)
  );

  // prg bank for the $8000 / $C000 window
  always_comb begin
    case (prg_mode_e'(bank.control[3:2]))
      PRG_MODE_32K_A, PRG_MODE_32K_B: begin
        rom_bank = {bank.prg_sel[BANK_W-1:1], req_i.bus_address[14]};
      end
      PRG_MODE_FIX_LOW: rom_bank = req_i.bus_address[14] ? bank.prg_sel : '0;
      PRG_MODE_FIX_TOP: rom_bank = req_i.bus_address[14] ? bank.last_bank : bank.prg_sel;
      default:          rom_bank = bank.prg_sel;
    endcase
  end

  // chr bank for the $0000 / $1000 window
  always_comb begin
    if (!bank.control[4]) begin
      chr_bank = {bank.chr_lo[BANK_W-1:1], req_i.bus_address[12]};
    end else begin
      chr_bank = req_i.bus_address[12] ? bank.chr_hi : bank.chr_lo;
    end
  end

  // ram offset: (address - $6000) mod size, value below eight times the size
  always_comb begin
    ram_off = {3'b000, req_i.bus_address[12:0]};
    for (int k = 2; k >= 0; k--) begin
      if (ram_off >= (RamBytes << k)) begin
        ram_off = ram_off - (RamBytes << k);
      end
    end
  end
  assign ram_idx = ram_off[RAM_AW-1:0];

  // access decode
  always_comb begin
    dec_target = TGT_NONE;
    dec_mapped = '0;
    dec_wen    = 1'b0;
    reg_wr     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    if (is_cpu) begin
      if (req_i.bus_address[15]) begin
        if (req_i.func == FUNC_CPU_RD) begin
          dec_target = TGT_PRG_ROM;
          dec_mapped = {rom_bank, req_i.bus_address[PRG_OFS_W-1:0]};
        end else begin
          reg_wr = accept;
        end
      end else if (req_i.bus_address[14:13] == 2'b11) begin
        dec_target = TGT_PRG_RAM;
        dec_mapped = {2'b00, ram_off};
        if (req_i.func == FUNC_CPU_RD) begin
          ram_re = accept;
        end else begin
          ram_we = accept;
        end
      end
    end else if (req_i.bus_address[15:13] == 3'b000) begin
      dec_target = TGT_CHR;
      dec_mapped = {2'b00, chr_bank, req_i.bus_address[CHR_OFS_W-1:0]};
      dec_wen    = (req_i.func == FUNC_PPU_WR);
    end
  end

  // prg ram, one port, registered read
  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      mem[ram_idx] <= req_i.write_value;
    end
    if (ram_re) begin
      rd_q <= mem[ram_idx];
    end
  end

  // stage valid bits
  always_comb begin
    s1_valid_d  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_q);
    out_valid_d = s1_move ? 1'b1 : (rsp_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // decode stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_target_q <= dec_target;
      s1_mapped_q <= dec_mapped;
      s1_wen_q    <= dec_wen;
      s1_rvalid_q <= ram_re;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_target_q <= s1_target_q;
      out_mapped_q <= s1_mapped_q;
      out_wen_q    <= s1_wen_q;
      out_rdata_q  <= s1_rvalid_q ? rd_q : '0;
      out_rvalid_q <= s1_rvalid_q;
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.target           = out_target_q;
  assign rsp_o.mapped_address   = out_mapped_q;
  assign rsp_o.chr_write_enable = out_wen_q;
  assign rsp_o.ram_read_data    = out_rdata_q;
  assign rsp_o.ram_data_valid   = out_rvalid_q;

`ifndef SYNTHESIS
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted transaction lost in decode stage");
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> s1_valid_q && out_valid_q && !rsp_o.ready)
    else $error("input stalled without a full pipeline");
  a_ram_read_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_rvalid_q && !accept |=> $stable(rd_q))
    else $error("ram read data changed while its transaction waits");
`endif

endmodule

`default_nettype wire
